/* sv/scf_pkg.sv */
package scf_pkg;

    // Frame marker bytes
    localparam logic [7:0] START_PARAM = 8'h02;
    localparam logic [7:0] START_CMD   = 8'h18;
    localparam logic [7:0] END_MARK    = 8'h03;
    localparam logic [7:0] CR_CHAR     = 8'h0D;
    localparam logic [7:0] HEX_DIGIT0  = 8'h30;  // '0'
    localparam logic [7:0] HEX_ALPHA   = 8'h57;  // 'a' - 10

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       first_byte;
        logic       last_byte;
        logic       is_command;
    } in_word_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_end;
    } out_word_t;

    // One classified item, handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       cmd;
        logic       csum_en;
        logic [7:0] csum;
    } job_t;

    typedef enum logic [2:0] {
        PH_BEGIN,
        PH_BODY,
        PH_END,
        PH_HEX_HI,
        PH_HEX_LO,
        PH_CR
    } phase_t;

    function automatic logic [7:0] hex_lower(input logic [3:0] nib);
        logic [7:0] ext;
        ext = {4'h0, nib};
        return (nib < 4'd10) ? (HEX_DIGIT0 + ext) : (HEX_ALPHA + ext);
    endfunction

endpackage

/* sv/scf_front.sv */
module scf_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  scf_pkg::in_word_t in_word,
    input  logic              cfg_we,
    input  logic              cfg_data,
    output scf_pkg::job_t     job
);
    import scf_pkg::*;

    logic       csum_en_reg;
    logic       csum_en_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] start_byte;
    logic [7:0] sum_base;
    logic [7:0] sum_body;
    logic [7:0] sum_end;

    always_comb
    begin
        start_byte = in_word.is_command ? START_CMD : START_PARAM;
        sum_base   = in_word.first_byte ? start_byte : sum_reg;
        sum_body   = sum_base + in_word.msg_byte;
        sum_end    = sum_body + END_MARK;
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (accept)
        begin
            sum_next = in_word.last_byte ? 8'h00 : sum_body;
        end
        csum_en_next = cfg_we ? cfg_data : csum_en_reg;
    end

    always_comb
    begin
        job.data    = in_word.msg_byte;
        job.first   = in_word.first_byte;
        job.last    = in_word.last_byte;
        job.cmd     = in_word.is_command;
        job.csum_en = csum_en_reg;
        job.csum    = sum_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= 8'h00;
            csum_en_reg <= 1'b0;
        end
        else
        begin
            sum_reg     <= sum_next;
            csum_en_reg <= csum_en_next;
        end
    end

`ifndef SYNTH
    a_sum_clear_after_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && in_word.last_byte) |=> (sum_reg == 8'h00)
    ) else $error("running sum not cleared after closing byte");
`endif

endmodule

/* sv/scf_queue.sv */
module scf_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  scf_pkg::job_t wr_job,
    output logic          full,
    input  logic          rd_en,
    output logic          head_valid,
    output scf_pkg::job_t head_job
);
    import scf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    job_t          slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_wr;
    logic          do_rd;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_wr      = wr_en && !full;
    assign do_rd      = rd_en && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT
    ) else $error("queue count above depth");
`endif

endmodule

/* sv/scf_back.sv */
module scf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  scf_pkg::job_t      head_job,
    output logic               rd_en,
    output logic               empty,
    input  logic               pop,
    output scf_pkg::out_word_t pop_data
);
    import scf_pkg::*;

    phase_t    phase_reg;
    phase_t    phase_next;
    out_word_t out_reg;
    out_word_t out_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      advance;
    logic      job_done;
    logic      pop_ok;

    assign empty    = !out_valid_reg;
    assign pop_data = out_reg;
    assign pop_ok   = pop && out_valid_reg;
    // output slot is free or drains this cycle
    assign advance  = head_valid && (!out_valid_reg || pop_ok);
    assign rd_en    = advance && job_done;

    // next phase of the head job
    always_comb
    begin
        phase_next = phase_reg;
        if (advance)
        begin
            unique case (phase_reg)
                PH_BEGIN:
                begin
                    if (head_job.first)
                    begin
                        phase_next = PH_BODY;
                    end
                    else
                    begin
                        phase_next = head_job.last ? PH_END : PH_BEGIN;
                    end
                end
                PH_BODY:   phase_next = head_job.last ? PH_END : PH_BEGIN;
                PH_END:    phase_next = head_job.csum_en ? PH_HEX_HI : PH_CR;
                PH_HEX_HI: phase_next = PH_HEX_LO;
                PH_HEX_LO: phase_next = PH_CR;
                PH_CR:     phase_next = PH_BEGIN;
                default:   phase_next = PH_BEGIN;
            endcase
        end
    end

    // byte for the current phase
    always_comb
    begin
        out_next.tx_byte   = head_job.data;
        out_next.frame_end = 1'b0;
        job_done           = 1'b0;
        unique case (phase_reg)
            PH_BEGIN:
            begin
                if (head_job.first)
                begin
                    out_next.tx_byte = head_job.cmd ? START_CMD : START_PARAM;
                end
                job_done = !head_job.first && !head_job.last;
            end
            PH_BODY:   job_done = !head_job.last;
            PH_END:    out_next.tx_byte = END_MARK;
            PH_HEX_HI: out_next.tx_byte = hex_lower(head_job.csum[7:4]);
            PH_HEX_LO: out_next.tx_byte = hex_lower(head_job.csum[3:0]);
            PH_CR:
            begin
                out_next.tx_byte   = CR_CHAR;
                out_next.frame_end = 1'b1;
                job_done           = 1'b1;
            end
            default:   job_done = 1'b1;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop_ok)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BEGIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_phase_has_job: assert property (
        @(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_BEGIN) |-> head_valid
    ) else $error("mid-job phase with no job at queue head");

    a_end_is_cr: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.frame_end) |-> (out_reg.tx_byte == CR_CHAR)
    ) else $error("frame_end on a byte other than carriage return");
`endif

endmodule

/* sv/serial_command_framer_unit.sv */
// Serial command framer.
// Input side is a queue write port: a word (msg_byte, first/last marks,
// is_command) is taken on a clock edge with push high and full low.
// Output side is a queue read port: while empty is low, pop_data holds the
// oldest framed byte; it is taken on an edge with pop high.
// Each input word yields one to six bytes: optional start byte, the body
// byte, and on the last byte the end mark, optional two hex checksum
// characters and a carriage return flagged by frame_end.
// cfg_valid/cfg_ready/cfg_data write checksum_enable (cfg_ready is always
// high); it is sampled when the front classifies a word.
// The first byte of a word reaches pop_data via the job queue and the output
// register. Throughput: one body word per cycle while pop stays high; the
// start byte and the trailer take extra back-end steps. The back end
// sequencer emitting one byte per cycle while pop is high sets this rate.
// When the receiver stalls, the output register holds and the job queue
// (QUEUE_DEPTH words) fills; full rises once it is exhausted.
// Reset clears the running sum, checksum_enable, the queue and the output
// valid flag; the block accepts words on the first cycle after reset.
module serial_command_framer_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  scf_pkg::in_word_t  push_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data,
    output logic               empty,
    input  logic               pop,
    output scf_pkg::out_word_t pop_data
);
    import scf_pkg::*;

    job_t front_job;
    job_t head_job;
    logic accept;
    logic cfg_we;
    logic head_valid;
    logic rd_en;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign accept    = push && !full;

    // front: running sum and per-word classification
    scf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_word  (push_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .job      (front_job)
    );

    // job queue decouples front from back
    scf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (accept),
        .wr_job     (front_job),
        .full       (full),
        .rd_en      (rd_en),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // back: byte sequencer and output register
    scf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .rd_en      (rd_en),
        .empty      (empty),
        .pop        (pop),
        .pop_data   (pop_data)
    );

endmodule

/* sim/serial_command_framer_unit_test.sv */
`timescale 1ns / 1ps

// Framer testbench. Words go in through the push/full side and framed bytes
// come out through the empty/pop side. A local predictor keeps its own
// running frame sum and checksum switch. On every accepted word it queues
// the bytes that word should produce. A checker pops one expectation per
// accepted output byte and compares it field by field.
module serial_command_framer_unit_test;
    import scf_pkg::*;

    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 10;
    localparam int MAX_SHOWN       = 10;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 20;
    localparam int RUN_LIMIT_NS    = 2_000_000;

    // ASCII bases for the lowercase hex checksum characters
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_A    = 8'h61;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    in_word_t   push_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;
    logic       empty;
    logic       pop;
    out_word_t  pop_data;

    serial_command_framer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .push_data (push_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop       (pop),
        .pop_data  (pop_data)
    );

    // Predictor state: mirrors the block's running sum and checksum switch.
    out_word_t  tx_expected[$];
    logic [7:0] frame_sum;
    logic       checksum_on;

    int errors;
    bit sender_gaps_on;
    bit receiver_stalls_on;
    int hold_cycles;     // long receiver hold-off, counted down by the receiver
    int stall_left;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
        if (nib < 4'd10)
            return ASCII_ZERO + 8'(nib);
        return ASCII_A + 8'(nib) - 8'd10;
    endfunction

    function automatic void expect_byte(input logic [7:0] b, input logic closing);
        out_word_t o;
        o.tx_byte   = b;
        o.frame_end = closing;
        tx_expected.push_back(o);
    endfunction

    // Expected output for one accepted word:
    // [start] body [end mark, [hex hi, hex lo], CR]
    function automatic void predict_framing(input in_word_t w);
        logic [7:0] start_b;
        if (w.first_byte)
        begin
            // A first mark always restarts the sum, open frame or not
            start_b   = w.is_command ? START_CMD : START_PARAM;
            frame_sum = start_b;
            expect_byte(start_b, 1'b0);
        end
        // Body bytes count toward the sum even outside a frame
        frame_sum = frame_sum + w.msg_byte;
        expect_byte(w.msg_byte, 1'b0);
        if (w.last_byte)
        begin
            frame_sum = frame_sum + END_MARK;
            expect_byte(END_MARK, 1'b0);
            if (checksum_on)
            begin
                expect_byte(ascii_hex(frame_sum[7:4]), 1'b0);
                expect_byte(ascii_hex(frame_sum[3:0]), 1'b0);
            end
            expect_byte(CR_CHAR, 1'b1);
            frame_sum = 8'h00;
        end
    endfunction

    function automatic in_word_t make_word(input logic [7:0] data, input logic first,
                                           input logic last, input logic cmd);
        in_word_t w;
        w.msg_byte   = data;
        w.first_byte = first;
        w.last_byte  = last;
        w.is_command = cmd;
        return w;
    endfunction

    // Offers one word with an optional idle burst in front. Push stays high
    // after acceptance; the next word or wait_drained drives it again on the
    // following falling edge, so push sees one update per time step.
    task automatic send_word(input in_word_t w);
        int gap;
        gap = 0;
        if (sender_gaps_on && $urandom_range(3) == 0)
            gap = $urandom_range(1, 5);
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push      <= 1'b1;
        push_data <= w;
        do
            @(posedge clk);
        while (full);
        predict_framing(w);
    endtask

    // Well-formed message with random content; is_command is random on
    // non-first words because the block should ignore it there.
    task automatic send_frame(input int len, input logic cmd);
        int i;
        for (i = 0; i < len; i++)
            send_word(make_word(8'($urandom_range(255)), i == 0, i == len - 1,
                                (i == 0) ? cmd : 1'($urandom_range(1))));
    endtask

    // Stop offering words and wait until every expected byte has come out.
    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        while (tx_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_checksum(input logic enable);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= enable;
        do
            @(posedge clk);
        while (!cfg_ready);
        checksum_on = enable;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: long hold-off first, then random stall bursts.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (receiver_stalls_on && $urandom_range(3) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Output checker: one expectation per accepted output byte.
    always @(posedge clk)
    begin : check_output
        out_word_t want;
        if (rst_n && !empty && pop)
        begin
            if (tx_expected.size() == 0)
            begin
                if (errors < MAX_SHOWN)
                    $display("[%0t] unexpected word: tx_byte=%02h frame_end=%0b",
                             $realtime, pop_data.tx_byte, pop_data.frame_end);
                errors++;
            end
            else
            begin
                want = tx_expected.pop_front();
                if (pop_data.tx_byte !== want.tx_byte ||
                    pop_data.frame_end !== want.frame_end)
                begin
                    if (errors < MAX_SHOWN)
                        $display({"[%0t] mismatch: tx_byte exp %02h got %02h,",
                                  " frame_end exp %0b got %0b"},
                                 $realtime, want.tx_byte, pop_data.tx_byte,
                                 want.frame_end, pop_data.frame_end);
                    errors++;
                end
            end
        end
    end

    // Body bytes with no open frame, straight after reset (sum starts at 0).
    task automatic test_orphan_bytes();
        send_word(make_word(8'h5A, 1'b0, 1'b0, 1'b1));
        send_word(make_word(8'hFF, 1'b0, 1'b1, 1'b0));
        set_checksum(1'b1);
        // sum was cleared by the CR above
        send_word(make_word(8'h00, 1'b0, 1'b1, 1'b0));
    endtask

    // First and last on one word: whole frame from a single step.
    task automatic test_single_byte_frames();
        send_word(make_word(8'h00, 1'b1, 1'b1, 1'b0));
        send_word(make_word(8'hFF, 1'b1, 1'b1, 1'b1));
        send_word(make_word(8'h80, 1'b1, 1'b1, 1'b0));
        send_word(make_word(8'h7F, 1'b1, 1'b1, 1'b1));
        set_checksum(1'b0);
        send_word(make_word(8'hFF, 1'b1, 1'b1, 1'b0));
        send_word(make_word(8'h00, 1'b1, 1'b1, 1'b1));
        set_checksum(1'b1);
    endtask

    // Longer frames; all-ones body wraps the sum several times.
    task automatic test_multi_byte_frames();
        send_word(make_word(8'hFF, 1'b1, 1'b0, 1'b1));
        send_word(make_word(8'hFF, 1'b0, 1'b0, 1'b0));
        send_word(make_word(8'hFF, 1'b0, 1'b0, 1'b1));
        send_word(make_word(8'hFF, 1'b0, 1'b1, 1'b0));
        send_word(make_word(8'h01, 1'b1, 1'b0, 1'b0));
        send_word(make_word(8'h02, 1'b0, 1'b0, 1'b1));
        send_word(make_word(8'h03, 1'b0, 1'b1, 1'b1));
    endtask

    // A first mark inside an open frame drops the old frame, no trailer.
    task automatic test_reopened_frame();
        send_word(make_word(8'h11, 1'b1, 1'b0, 1'b0));
        send_word(make_word(8'h22, 1'b0, 1'b0, 1'b0));
        send_word(make_word(8'h33, 1'b1, 1'b0, 1'b1));
        send_word(make_word(8'h44, 1'b0, 1'b1, 1'b0));
        send_word(make_word(8'h55, 1'b1, 1'b0, 1'b0));
        send_word(make_word(8'h66, 1'b1, 1'b1, 1'b1));
    endtask

    // Receiver holds off while the sender keeps offering back to back, so
    // the job queue fills and full must stall the input.
    task automatic test_backpressure();
        int i;
        sender_gaps_on = 1'b0;
        hold_cycles    = HOLD_OFF_CYCLES;
        for (i = 0; i < 6; i++)
            send_frame(5, 1'($urandom_range(1)));
        wait_drained();
        sender_gaps_on = 1'b1;
    endtask

    // Mostly well-formed messages with random content, some cut short
    // (next first mark reopens), some stray bytes outside any frame.
    task automatic test_random_traffic(input int n_words);
        int sent;
        int len;
        int kind;
        int i;
        sent = 0;
        while (sent < n_words)
        begin
            kind = $urandom_range(99);
            len  = ($urandom_range(7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
            if (kind < 80)
            begin
                send_frame(len, 1'($urandom_range(1)));
                sent += len;
            end
            else if (kind < 92)
            begin
                for (i = 0; i < len; i++)
                    send_word(make_word(8'($urandom_range(255)), i == 0, 1'b0,
                                        1'($urandom_range(1))));
                sent += len;
            end
            else
            begin
                send_word(make_word(8'($urandom_range(255)), 1'b0,
                                    1'($urandom_range(1)), 1'($urandom_range(1))));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        push               = 1'b0;
        push_data          = '0;
        cfg_valid          = 1'b0;
        cfg_data           = 1'b0;
        pop                = 1'b0;
        frame_sum          = 8'h00;
        checksum_on        = 1'b0;
        errors             = 0;
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        hold_cycles        = 0;
        stall_left         = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_orphan_bytes();
        test_single_byte_frames();
        test_multi_byte_frames();
        test_reopened_frame();
        test_backpressure();

        test_random_traffic(120);
        set_checksum(1'b0);
        test_random_traffic(120);
        set_checksum(1'b1);

        // Last stretch at full rate on both sides
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        test_random_traffic(100);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
